// ===== sv/lphi_pkg.sv =====
// Shared types and constants for the linear probing hash insert block.
`timescale 1ns / 1ps

package lphi_pkg;

  // Operation carried by an input item
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // Status carried by a result item
  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_FULL   = 2'd1,
    ST_READ   = 2'd2
  } status_t;

  localparam int KEY_W  = 31;
  localparam int SLOT_W = 3;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic              slot_used;
    logic [KEY_W-1:0]  key_out;
  } out_item_t;

endpackage

// ===== sv/linear_probing_hash_insert_core.sv =====
// Open-addressing hash table with linear probing, one item at a time.
//
// Input channel in_valid/in_stall/in_data carries an insert (key) or a read
// (slot). Each item gives exactly one result on out_valid/out_stall/out_data.
// An insert first works out key modulo SLOTS in a remainder unit by
// reciprocal multiplication, then probes one slot a cycle from the home
// slot, wrapping, until it finds a free one or has seen every slot (a full
// result). An insert probes 1 to SLOTS slots; a read goes through the
// registered key memory. in_stall is high from accept until the result is
// loaded into the output register, so the block takes no new item before
// it is through with the last one. The output register holds the result
// while out_stall is high; the next item is accepted meanwhile, and its
// result waits in the block until the output register frees.
// Reset clears the table (all slots free) and the result channel at once;
// key storage is not cleared, free slots read back as zero.
`timescale 1ns / 1ps

module linear_probing_hash_insert_core #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lphi_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lphi_pkg::out_item_t out_data
);
  import lphi_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int AW = IW + SLOT_W;
  localparam logic [IW-1:0] LastSlot = IW'(SLOTS - 1);
  localparam logic [AW-1:0] SlotsExt = AW'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_RDMEM,
    S_RDOUT,
    S_HOLD
  } state_t;

  state_t            state;
  logic [KEY_W-1:0]  key_q;
  logic [IW-1:0]     pos;
  logic [IW-1:0]     pcnt;
  logic [IW-1:0]     rd_addr;
  logic              rd_hit;
  logic [SLOT_W-1:0] rd_slot;
  logic [KEY_W-1:0]  rd_data;
  logic              rd_used;
  out_item_t         pend;
  logic [SLOTS-1:0]  valid;
  logic [KEY_W-1:0]  mem [SLOTS];

  logic              accept;
  logic              mod_start;
  logic              mod_done;
  logic [IW-1:0]     mod_rem;
  logic              wr_en;
  logic [AW-1:0]     slot_ext;
  logic [AW-1:0]     pos_ext;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign mod_start = accept && (in_data.op == OP_INSERT);
  assign wr_en     = (state == S_PROBE) && !valid[pos];
  assign slot_ext  = AW'(in_data.slot);
  assign pos_ext   = AW'(pos);
  assign rd_used   = rd_hit && valid[rd_addr];

  // Home slot
  lphi_mod_unit #(
    .SLOTS(SLOTS)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .key  (in_data.key),
    .done (mod_done),
    .rem  (mod_rem)
  );

  // Key store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos] <= key_q;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer, slot valid bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the shown item once taken, unless a held result replaces it
      if (out_valid && !out_stall && (state != S_HOLD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key_q <= in_data.key;
            if (in_data.op == OP_READ) begin
              rd_addr <= slot_ext[IW-1:0];
              rd_hit  <= (slot_ext < SlotsExt);
              rd_slot <= in_data.slot;
              state   <= S_RDMEM;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            pos   <= mod_rem;
            pcnt  <= '0;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          // claim a free slot, or advance with wrap until every slot is seen
          if (!valid[pos]) begin
            valid[pos]      <= 1'b1;
            pend.status     <= ST_STORED;
            pend.slot_index <= pos_ext[SLOT_W-1:0];
            pend.slot_used  <= 1'b0;
            pend.key_out    <= '0;
            state           <= S_HOLD;
          end else if (pcnt == LastSlot) begin
            pend.status     <= ST_FULL;
            pend.slot_index <= '0;
            pend.slot_used  <= 1'b0;
            pend.key_out    <= '0;
            state           <= S_HOLD;
          end else begin
            pos  <= (pos == LastSlot) ? '0 : pos + 1'b1;
            pcnt <= pcnt + 1'b1;
          end
        end
        S_RDMEM: begin
          state <= S_RDOUT;
        end
        S_RDOUT: begin
          pend.status     <= ST_READ;
          pend.slot_index <= rd_slot;
          pend.slot_used  <= rd_used;
          pend.key_out    <= rd_used ? rd_data : '0;
          state           <= S_HOLD;
        end
        S_HOLD: begin
          // hold the result until the output register is free
          if (!out_valid || !out_stall) begin
            out_data  <= pend;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Slots are only ever claimed between resets
  a_valid_grows: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> $countones(valid) >= $countones($past(valid)))
    else $error("slot valid bit cleared outside reset");

  // A full result means every slot is in use
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_FULL) |-> &valid)
    else $error("full status with a free slot");

  // A key write ends the probe with a stored result
  a_write_ends_probe: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (state == S_HOLD) && (pend.status == ST_STORED))
    else $error("probe continued after key write");

  // Probe never runs past the table size
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (pcnt <= LastSlot))
    else $error("probe count beyond table size");

endmodule

// ===== sv/lphi_mod_unit.sv =====
// Remainder unit: key modulo SLOTS by reciprocal multiplication.
`timescale 1ns / 1ps

module lphi_mod_unit #(
  parameter int SLOTS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lphi_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic [$clog2(SLOTS)-1:0]   rem
);
  import lphi_pkg::*;

  localparam int IW = $clog2(SLOTS);
  // Rounded-up reciprocal with this shift gives the exact quotient for every key
  localparam int SH = KEY_W + IW;
  localparam int MW = KEY_W + 1;
  localparam int PW = SH + IW;
  localparam logic [63:0] RecipFull = ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [MW-1:0] Recip = RecipFull[MW-1:0];
  localparam logic [IW-1:0] SlotsLow = IW'(SLOTS);

  logic          busy;
  logic [IW-1:0] quot_next;
  logic [IW-1:0] quot_low;
  logic [IW-1:0] key_low;

  // Low bits of the quotient
  assign quot_next = IW'((PW'(key) * PW'(Recip)) >> SH);

  // Pass start through busy into done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  // Key minus quotient times SLOTS; the remainder fits in the low bits
  always_ff @(posedge clk) begin
    if (start) begin
      quot_low <= quot_next;
      key_low  <= key[IW-1:0];
    end
    if (busy) begin
      rem <= key_low - quot_low * SlotsLow;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the linear probing hash insert core.
`timescale 1ns / 1ps

// Track the table contents and the queue of results still due from the core
class hash_table_scoreboard;
  int unsigned             n_slots;
  logic [30:0]             slot_key [64];
  bit                      slot_taken [64];
  lphi_pkg::out_item_t     due [$];
  int                      errors;

  function new(int unsigned slots);
    n_slots = slots;
    errors  = 0;
    for (int i = 0; i < 64; i++) begin
      slot_key[i]   = '0;
      slot_taken[i] = 1'b0;
    end
  endfunction

  // Work out the result of an accepted item and update the table copy
  function void note_item(lphi_pkg::in_item_t it);
    lphi_pkg::out_item_t res;
    int unsigned         pos;
    bit                  placed;
    res = '0;
    if (it.op == lphi_pkg::OP_READ) begin
      res.status     = lphi_pkg::ST_READ;
      res.slot_index = it.slot;
      if (it.slot < n_slots && slot_taken[it.slot]) begin
        res.slot_used = 1'b1;
        res.key_out   = slot_key[it.slot];
      end
    end else begin
      // Probe from the home slot, wrapping, until a free slot turns up or every slot is seen
      res.status = lphi_pkg::ST_FULL;
      pos        = it.key % n_slots;
      placed     = 1'b0;
      for (int n = 0; n < n_slots && !placed; n++) begin
        if (!slot_taken[pos]) begin
          slot_taken[pos] = 1'b1;
          slot_key[pos]   = it.key;
          res.status      = lphi_pkg::ST_STORED;
          res.slot_index  = pos[lphi_pkg::SLOT_W-1:0];
          placed          = 1'b1;
        end else begin
          pos = (pos + 1 == n_slots) ? 0 : pos + 1;
        end
      end
    end
    due.insert(due.size(), res);
  endfunction

  // Compare one result item with the oldest one due
  function void check_result(lphi_pkg::out_item_t got);
    lphi_pkg::out_item_t want;
    if (due.size() == 0) begin
      if (errors < 10)
        $display("unexpected result: status=%0d idx=%0d used=%0b key=%h",
                 got.status, got.slot_index, got.slot_used, got.key_out);
      errors++;
    end else begin
      want = due.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.slot_used !== want.slot_used || got.key_out !== want.key_out) begin
        if (errors < 10)
          $display("mismatch: want status=%0d idx=%0d used=%0b key=%h,",
                   want.status, want.slot_index, want.slot_used, want.key_out,
                   " got status=%0d idx=%0d used=%0b key=%h",
                   got.status, got.slot_index, got.slot_used, got.key_out);
        errors++;
      end
    end
  endfunction
endclass

module tb_top;
  import lphi_pkg::*;

  localparam int TABLE_SLOTS  = 8;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  bit        calm;
  int        cycle_count;
  hash_table_scoreboard sb;

  linear_probing_hash_insert_core #(
    .SLOTS(TABLE_SLOTS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Build items; the ignored field carries random bits
  function automatic in_item_t insert_item(logic [KEY_W-1:0] key);
    in_item_t it;
    it.op   = OP_INSERT;
    it.key  = key;
    it.slot = SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
    return it;
  endfunction

  function automatic in_item_t read_item(logic [SLOT_W-1:0] slot);
    in_item_t it;
    it.op   = OP_READ;
    it.key  = KEY_W'($urandom);
    it.slot = slot;
    return it;
  endfunction

  function automatic in_item_t random_request();
    in_item_t it;
    logic [KEY_W-1:0] key;
    case ($urandom_range(0, 9))
      0:       key = '0;
      1:       key = KEY_MAX;
      default: key = KEY_W'($urandom);
    endcase
    it.op   = ($urandom_range(0, 1) == 1) ? OP_READ : OP_INSERT;
    it.key  = key;
    it.slot = SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
    return it;
  endfunction

  // Drop valid for a random burst now and then
  task automatic sender_pause();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Hold the item until the core takes it, then note it
  task automatic send_item(in_item_t it);
    sender_pause();
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  // Stop the run if the core hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("linear_probing_hash_insert_core verification failed");
    $finish;
  end

  // Result side: check accepted items, stall in random bursts
  initial begin
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        sb.check_result(out_data);
      if (hold > 0)
        hold--;
      else if (!calm && $urandom_range(0, 4) == 0)
        hold = $urandom_range(1, 15);
      out_stall <= (hold > 0);
    end
  end

  // Stimulus
  initial begin
    sb       = new(TABLE_SLOTS);
    calm     = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty table, then collisions, wrap from the last slot and duplicates
    send_item(read_item(3'd0));
    send_item(read_item(3'd7));
    send_item(insert_item('0));
    send_item(insert_item(KEY_MAX));
    send_item(insert_item(31'd15));
    send_item(insert_item('0));
    send_item(read_item(3'd7));
    send_item(read_item(3'd2));
    send_item(read_item(3'd4));
    send_item(insert_item(31'h2AAA_AAAA));
    send_item(insert_item(31'h5555_5555));
    send_item(insert_item(31'd4));
    send_item(insert_item(31'd8));
    send_item(read_item(3'd6));
    // Table now full: keys are dropped
    send_item(insert_item(31'd1));
    send_item(insert_item(KEY_MAX));
    for (int s = 0; s < TABLE_SLOTS; s++)
      send_item(read_item(s[SLOT_W-1:0]));

    // Random part, with no idling over the last stretch
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - CALM_ITEMS)
        calm = 1'b1;
      send_item(random_request());
    end
    in_valid <= 1'b0;

    // Drain
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("linear_probing_hash_insert_core verification clean");
    end else begin
      $display("linear_probing_hash_insert_core verification failed");
    end
    $finish;
  end

endmodule
